[rtl/bm3_pkg.sv]
// ----------------------------------------------------------------------------
// bm3_pkg: shared types and constants for the 3x3 binary morphology unit
// Register indexes, operation codes, and the item record between the front
// part and the two filter stages.
// ----------------------------------------------------------------------------
`default_nettype none
package bm3_pkg;

  // Configuration register indexes
  localparam logic [1:0] RegWidth  = 2'd0;
  localparam logic [1:0] RegHeight = 2'd1;
  localparam logic [1:0] RegFgVal  = 2'd2;
  localparam logic [1:0] RegMode   = 2'd3;

  // Operation modes
  typedef enum logic [1:0] {
    OpDilate = 2'd0,
    OpErode  = 2'd1,
    OpOpen   = 2'd2,
    OpClose  = 2'd3
  } op_mode_e;

  localparam logic [7:0] PixMax = 8'd255;

  // Item passed from the front queue to the stages
  typedef struct packed {
    logic       has_pixel;
    logic [7:0] pixel;
  } event_t;

endpackage
`default_nettype wire

[rtl/binary_morphology_3x3_unit.sv]
// Path: a result passes the front queue, the RAM read and the window/compare
//   registers, and waits for one row and one pixel of look-ahead per stage,
//   set by the 3x3 neighborhood.
// Throughput: one item per cycle while the output queue has room; each stage in use steps once per queue item.
// Reset: asynchronous, active low; clears counters, queues and valid flags.
//   Line buffer contents are not cleared. A register write restarts both stages.
// ----------------------------------------------------------------------------
// binary_morphology_3x3_unit: streaming 3x3 dilation/erosion/open/close
// Front queue feeds two cascaded stages; an output queue holds results.
// ----------------------------------------------------------------------------
`default_nettype none
module binary_morphology_3x3_unit #(
  parameter int MaxWidth  = 1024,
  parameter int MaxHeight = 1024
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        push,
  output logic             full,
  input  wire logic [7:0]  pixel_in_i,
  input  wire logic        flush_i,
  output logic             empty,
  input  wire logic        pop,
  output logic [7:0]       pixel_out_o,
  output logic             frame_last_o,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [10:0] cfg_data
);

  localparam int CW = $clog2(MaxWidth+1);
  localparam int RW = $clog2(MaxHeight+1);

  logic [10:0] width_q, height_q;
  logic [7:0]  fg_q;
  logic [1:0]  mode_q;
  logic        cfg_we;

  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q <= 11'd640; height_q <= 11'd480; fg_q <= '0; mode_q <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        bm3_pkg::RegWidth:  width_q  <= cfg_data;
        bm3_pkg::RegHeight: height_q <= cfg_data;
        bm3_pkg::RegFgVal:  fg_q     <= cfg_data[7:0];
        bm3_pkg::RegMode:   mode_q   <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  // Clamped frame size
  logic [CW-1:0] w_eff;
  logic [RW-1:0] h_eff;
  assign w_eff = (width_q == 11'd0) ? CW'(1) :
                 ({21'd0, width_q} > MaxWidth) ? CW'(MaxWidth) : CW'(width_q);
  assign h_eff = (height_q == 11'd0) ? RW'(1) :
                 ({21'd0, height_q} > MaxHeight) ? RW'(MaxHeight) : RW'(height_q);

  // Output queue with room accounting: an event is taken only if a slot is
  // free for every result that may still be in flight.
  logic [7:0] oq_pix_q [8];
  logic       oq_last_q [8];
  logic [2:0] oq_wr_q, oq_rd_q;
  logic [3:0] oq_cnt_q;
  logic [3:0] inflight_q;

  logic            ev_valid, ev_take;
  bm3_pkg::event_t ev;
  logic            two;
  logic            e1, l1, e2, l2, res_valid, res_last;
  logic [7:0]      r1, r2, res_pix;

  assign two     = (mode_q == bm3_pkg::OpOpen) || (mode_q == bm3_pkg::OpClose);
  assign ev_take = ev_valid && (oq_cnt_q + inflight_q < 4'd8);

  bm3_front u_front (
    .clk_i, .rst_ni, .clear_i(cfg_we),
    .push_i(push), .pixel_i(pixel_in_i), .flush_i(flush_i), .full_o(full),
    .ev_valid_o(ev_valid), .ev_o(ev), .ev_take_i(ev_take)
  );

  // Stage two runs behind stage one on the same events; it steps on stage one's output.
  logic s2_en_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) s2_en_q <= 1'b0;
    else s2_en_q <= 1'b0;
  end

  bm3_stage #(.MaxWidth(MaxWidth), .MaxHeight(MaxHeight)) u_stage1 (
    .clk_i, .rst_ni, .clear_i(cfg_we), .en_i(ev_take),
    .has_pixel_i(ev.has_pixel), .pixel_i(ev.pixel),
    .erode_i(mode_q == bm3_pkg::OpErode || mode_q == bm3_pkg::OpOpen),
    .fg_i(fg_q), .w_i(w_eff), .h_i(h_eff),
    .emit_o(e1), .res_o(r1), .last_o(l1)
  );

  // Stage one emits via its stage 1 and output registers; stage two steps on every
  // delayed event, with a pixel when stage one emitted.
  logic [1:0] ev_d_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) ev_d_q <= '0;
    else if (cfg_we) ev_d_q <= '0;
    else ev_d_q <= {ev_d_q[0], ev_take && two};
  end

  bm3_stage #(.MaxWidth(MaxWidth), .MaxHeight(MaxHeight)) u_stage2 (
    .clk_i, .rst_ni, .clear_i(cfg_we), .en_i(ev_d_q[1] || s2_en_q),
    .has_pixel_i(e1), .pixel_i(r1),
    .erode_i(mode_q == bm3_pkg::OpClose),
    .fg_i(fg_q), .w_i(w_eff), .h_i(h_eff),
    .emit_o(e2), .res_o(r2), .last_o(l2)
  );

  assign res_valid = two ? e2 : e1;
  assign res_pix   = two ? r2 : r1;
  assign res_last  = two ? l2 : l1;

  // In-flight events: taken but not yet past the last stage
  logic [3:0] fly_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) fly_q <= '0;
    else if (cfg_we) fly_q <= '0;
    else fly_q <= {fly_q[2:0], ev_take};
  end
  always_comb begin
    inflight_q = two ? 4'($countones(fly_q)) : 4'($countones(fly_q[1:0]));
  end

  // Output queue
  logic do_pop;
  assign do_pop = pop && !empty;
  assign empty  = (oq_cnt_q == 4'd0);
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      oq_wr_q <= '0; oq_rd_q <= '0; oq_cnt_q <= '0;
    end else if (cfg_we) begin
      oq_wr_q <= '0; oq_rd_q <= '0; oq_cnt_q <= '0;
    end else begin
      if (res_valid) oq_wr_q <= oq_wr_q + 3'd1;
      if (do_pop) oq_rd_q <= oq_rd_q + 3'd1;
      oq_cnt_q <= oq_cnt_q + {3'b0, res_valid} - {3'b0, do_pop};
    end
  end
  always_ff @(posedge clk_i) begin
    if (res_valid) begin
      oq_pix_q[oq_wr_q]  <= res_pix;
      oq_last_q[oq_wr_q] <= res_last;
    end
  end
  assign pixel_out_o  = oq_pix_q[oq_rd_q];
  assign frame_last_o = oq_last_q[oq_rd_q];

endmodule
`default_nettype wire

[rtl/bm3_ram.sv]
// ----------------------------------------------------------------------------
// bm3_ram: generic single-write, single-read RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
`default_nettype none
module bm3_ram #(
  parameter int Width = 8,
  parameter int Depth = 4096
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // Storage and registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule
`default_nettype wire

[rtl/bm3_front.sv]
// ----------------------------------------------------------------------------
// bm3_front: input queue of the morphology unit
// Accepts pixel and flush items and holds them in a short queue until the
// stage pipeline takes them.
// ----------------------------------------------------------------------------
`default_nettype none
module bm3_front (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            clear_i,
  input  wire logic            push_i,
  input  wire logic [7:0]      pixel_i,
  input  wire logic            flush_i,
  output logic                 full_o,
  output logic                 ev_valid_o,
  output bm3_pkg::event_t      ev_o,
  input  wire logic            ev_take_i
);

  logic [1:0]       wr_q, rd_q;
  logic [2:0]       cnt_q;
  bm3_pkg::event_t  buf_q [4];

  assign full_o     = cnt_q[2];
  assign ev_valid_o = (cnt_q != 3'd0);
  assign ev_o       = buf_q[rd_q];

  // Queue pointers and count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else if (clear_i) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i && !full_o) wr_q <= wr_q + 2'd1;
      if (ev_take_i && ev_valid_o) rd_q <= rd_q + 2'd1;
      cnt_q <= cnt_q + {2'b0, push_i && !full_o} - {2'b0, ev_take_i && ev_valid_o};
    end
  end

  // Queue storage
  always_ff @(posedge clk_i) begin
    if (push_i && !full_o) begin
      buf_q[wr_q] <= '{has_pixel: !flush_i, pixel: pixel_i};
    end
  end

endmodule
`default_nettype wire

[rtl/bm3_stage.sv]
// ----------------------------------------------------------------------------
// bm3_stage: one 3x3 dilation or erosion stage
// Line buffer of four rows in RAM, pending-count readiness, and a pipeline:
// RAM read of the three rows of the column right of the output, then a
// sliding window and the neighbor test.
// ----------------------------------------------------------------------------
`default_nettype none
module bm3_stage #(
  parameter int MaxWidth  = 1024,
  parameter int MaxHeight = 1024
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          clear_i,
  input  wire logic                          en_i,
  input  wire logic                          has_pixel_i,
  input  wire logic [7:0]                    pixel_i,
  input  wire logic                          erode_i,
  input  wire logic [7:0]                    fg_i,
  input  wire logic [$clog2(MaxWidth+1)-1:0] w_i,
  input  wire logic [$clog2(MaxHeight+1)-1:0] h_i,
  output logic                               emit_o,
  output logic [7:0]                         res_o,
  output logic                               last_o
);

  localparam int CW = $clog2(MaxWidth+1);
  localparam int RW = $clog2(MaxHeight+1);
  localparam int AW = $clog2(MaxWidth);
  localparam int LW = $clog2(2*MaxWidth+3);

  logic [CW-1:0] in_col_q, out_col_q;
  logic [RW-1:0] in_row_q, out_row_q;
  logic [1:0]    in_slot_q, out_slot_q;
  logic [LW-1:0] lag_q;
  logic [LW-1:0] lag_inc;
  logic [LW-1:0] need;
  logic          ready;

  // Each row of a slot is its own RAM so three rows read per cycle; the
  // line buffer is 4 RAMs of MaxWidth, one per slot.
  logic [7:0] rd_data [4];

  // Readiness: output pixel needs its right and lower neighbors stored
  assign lag_inc = lag_q + LW'(has_pixel_i);
  always_comb begin
    if (out_row_q + RW'(1) < h_i) need = (out_col_q + CW'(1) < w_i) ? LW'(w_i) + LW'(1) : LW'(w_i);
    else need = (out_col_q + CW'(1) < w_i) ? LW'(1) : LW'(0);
  end
  assign ready = en_i && (lag_inc > need);

  // Position and count tracking
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_col_q <= '0; in_row_q <= '0; in_slot_q <= '0;
      out_col_q <= '0; out_row_q <= '0; out_slot_q <= '0; lag_q <= '0;
    end else if (clear_i) begin
      in_col_q <= '0; in_row_q <= '0; in_slot_q <= '0;
      out_col_q <= '0; out_row_q <= '0; out_slot_q <= '0; lag_q <= '0;
    end else if (en_i) begin
      if (has_pixel_i) begin
        if (in_col_q + CW'(1) < w_i) in_col_q <= in_col_q + CW'(1);
        else begin
          in_col_q  <= '0;
          in_slot_q <= in_slot_q + 2'd1;
          in_row_q  <= (in_row_q + RW'(1) < h_i) ? in_row_q + RW'(1) : '0;
        end
      end
      lag_q <= lag_inc - LW'(ready);
      if (ready) begin
        if (out_col_q + CW'(1) < w_i) out_col_q <= out_col_q + CW'(1);
        else begin
          out_col_q  <= '0;
          out_slot_q <= out_slot_q + 2'd1;
          out_row_q  <= (out_row_q + RW'(1) < h_i) ? out_row_q + RW'(1) : '0;
        end
      end
    end
  end

  // The window needs column c+1 of three rows; column c+1 may be written
  // this very cycle, so bypass the incoming pixel.
  logic [CW-1:0] rd_col;
  logic [AW-1:0] rd_addr;
  assign rd_col  = out_col_q + CW'(1);
  assign rd_addr = rd_col[AW-1:0];

  for (genvar g = 0; g < 4; g++) begin : g_rows
    bm3_ram #(.Width(8), .Depth(MaxWidth)) u_ram (
      .clk_i   (clk_i),
      .we_i    (en_i && has_pixel_i && (in_slot_q == 2'(g))),
      .waddr_i (in_col_q[AW-1:0]),
      .wdata_i (pixel_i),
      .re_i    (ready),
      .raddr_i (rd_addr),
      .rdata_o (rd_data[g])
    );
  end

  // Stage 1 registers: context for the read column
  logic          s1_valid_q, s1_last_q, s1_top_q, s1_bot_q, s1_right_q, s1_first_q;
  logic [1:0]    s1_slot_q;
  logic          s1_byp_q [3];
  logic [7:0]    s1_byp_pix_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) s1_valid_q <= 1'b0;
    else s1_valid_q <= ready && !clear_i;
  end

  always_ff @(posedge clk_i) begin
    if (ready) begin
      s1_slot_q    <= out_slot_q;
      s1_top_q     <= (out_row_q == '0);
      s1_bot_q     <= !(out_row_q + RW'(1) < h_i);
      s1_right_q   <= (rd_col < w_i);
      s1_first_q   <= (out_col_q == '0);
      s1_last_q    <= !(out_row_q + RW'(1) < h_i) && !(out_col_q + CW'(1) < w_i);
      s1_byp_pix_q <= pixel_i;
      for (int k = 0; k < 3; k++) begin
        s1_byp_q[k] <= has_pixel_i && (in_slot_q == out_slot_q + 2'(k) - 2'd1) &&
                       (in_col_q == rd_col);
      end
    end
  end

  // Sliding window: columns left, center, right for rows above, mid, below
  logic [7:0] win_q [3][3];
  logic [7:0] col_new [3];
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      col_new[k] = s1_byp_q[k] ? s1_byp_pix_q : rd_data[s1_slot_q + 2'(k) + 2'd3];
    end
  end

  // Window shift; the center column on the first column of a row comes from
  // the column-0 pixels captured as they are written (see below).
  logic       seed_q;
  logic [7:0] seed_col_q [3];

  logic [7:0] cur [3][3];
  logic       vr [3];
  logic [7:0] target;
  logic       hit;
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      cur[k][0] = win_q[k][1];
      cur[k][1] = s1_first_q ? seed_col_q[k] : win_q[k][2];
      cur[k][2] = col_new[k];
    end
    vr[0] = !s1_top_q; vr[1] = 1'b1; vr[2] = !s1_bot_q;
    target = erode_i ? ((fg_i != 8'd0) ? 8'd0 : bm3_pkg::PixMax) : fg_i;
    hit = 1'b0;
    for (int k = 0; k < 3; k++) begin
      for (int j = 0; j < 3; j++) begin
        if (!(k == 1 && j == 1) && vr[k] && !(j == 0 && s1_first_q) &&
            !(j == 2 && !s1_right_q) && (erode_i || k == 1 || j == 1) &&
            cur[k][j] == target) hit = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_valid_q) begin
      for (int k = 0; k < 3; k++) begin
        win_q[k][1] <= cur[k][1];
        win_q[k][2] <= cur[k][2];
      end
    end
  end

  // Column 0 of a row is stored when the row's first pixel is written.
  // Column 0 of the three rows around the next output row is captured as the
  // pixels arrive: each slot's column 0 when that slot is written at col 0.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) seed_q <= 1'b0;
    else seed_q <= 1'b0;
  end
  logic [7:0] c0_q [4];
  always_ff @(posedge clk_i) begin
    if (en_i && has_pixel_i && in_col_q == '0) c0_q[in_slot_q] <= pixel_i;
  end
  always_comb begin
    for (int k = 0; k < 3; k++) seed_col_q[k] = c0_q[s1_slot_q + 2'(k) + 2'd3];
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) emit_o <= 1'b0;
    else emit_o <= s1_valid_q && !clear_i && !seed_q;
  end
  always_ff @(posedge clk_i) begin
    if (s1_valid_q) begin
      res_o  <= (cur[1][1] != target && hit) ? target : cur[1][1];
      last_o <= s1_last_q;
    end
  end

endmodule
`default_nettype wire

[rtl/bm3_checker.sv]
// ----------------------------------------------------------------------------
// bm3_checker: port-level checks of the morphology unit
// Watches the queue handshakes and the configuration channel.
// ----------------------------------------------------------------------------
`default_nettype none
module bm3_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       push,
  input wire logic       full,
  input wire logic       empty,
  input wire logic       pop,
  input wire logic [7:0] pixel_out_o,
  input wire logic       cfg_valid,
  input wire logic       cfg_ready
);

  // A configuration write drops all pending results
  a_cfg_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_valid && cfg_ready |=> empty) else $error("results kept after config write");

  // A result not popped stays put
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && !pop && !(cfg_valid && cfg_ready) |=> !empty && $stable(pixel_out_o))
    else $error("waiting result changed");

  // Reset leaves the input queue open and the output queue empty
  a_reset: assert property (@(posedge clk_i) !rst_ni |-> empty && !full)
    else $error("queues not empty in reset");

endmodule

bind binary_morphology_3x3_unit bm3_checker u_bm3_checker (
  .clk_i, .rst_ni, .push, .full, .empty, .pop, .pixel_out_o, .cfg_valid, .cfg_ready
);
`default_nettype wire

[tb/tb_top.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: testbench for the 3x3 binary morphology unit
// Streams frames of pixels and flush items through all four operations over
// many frame sizes and foreground values. A scoreboard predicts each output
// pixel and its frame-last flag and checks results in order. Both the input
// and output handshakes idle at random.
// ----------------------------------------------------------------------------
module tb_top;
  import bm3_pkg::*;

  localparam int MaxW       = 1024;
  localparam int MaxH       = 1024;
  localparam int CycleLimit = 2000000;
  localparam int DrainWait  = 64;

  // Predicts the processed pixel stream and checks it in order
  class morph_scoreboard;
    typedef struct {
      int unsigned in_col, in_row, in_slot, out_col, out_row, out_slot, lag;
    } stage_s;
    typedef struct {
      logic [7:0] pix;
      bit         last;
    } result_s;

    stage_s      st[2];
    logic [7:0]  rows[2][4*MaxW];
    int unsigned width_reg, height_reg;
    logic [7:0]  fg_val;
    op_mode_e    mode;
    result_s     pending[$];
    int          errors;

    function new();
      width_reg  = 640;
      height_reg = 480;
      fg_val     = 8'd0;
      mode       = OpDilate;
      errors     = 0;
      foreach (rows[k, i]) rows[k][i] = 8'd0;
      restart();
    endfunction

    function void restart();
      foreach (st[k]) st[k] = '{default: 0};
    endfunction

    function int unsigned w_eff();
      return (width_reg < 1) ? 1 : (width_reg > MaxW) ? MaxW : width_reg;
    endfunction

    function int unsigned h_eff();
      return (height_reg < 1) ? 1 : (height_reg > MaxH) ? MaxH : height_reg;
    endfunction

    function void write_reg(logic [1:0] idx, logic [10:0] data);
      case (idx)
        RegWidth:  width_reg = data;
        RegHeight: height_reg = data;
        RegFgVal:  fg_val = data[7:0];
        RegMode:   mode = op_mode_e'(data[1:0]);
        default: ;
      endcase
      restart();
    endfunction

    // One event for stage k; returns 1 when the stage emits a pixel
    function bit stage_step(int k, bit has_pix, logic [7:0] pix, bit erode,
                            output logic [7:0] res, output bit last);
      int unsigned w, h, r, c, d, slot;
      int          rr, cc;
      logic [7:0]  center, target;
      bit          hit;
      w = w_eff();
      h = h_eff();
      hit = 0;
      res = 8'd0;
      last = 0;
      if (has_pix) begin
        rows[k][(st[k].in_slot & 3) * MaxW + st[k].in_col % MaxW] = pix;
        st[k].lag++;
        if (st[k].in_col + 1 < w) begin
          st[k].in_col++;
        end else begin
          st[k].in_col  = 0;
          st[k].in_slot = (st[k].in_slot + 1) & 3;
          st[k].in_row  = (st[k].in_row + 1 < h) ? st[k].in_row + 1 : 0;
        end
      end
      r = st[k].out_row;
      c = st[k].out_col;
      if (r + 1 < h) d = (c + 1 < w) ? w + 1 : w;
      else d = (c + 1 < w) ? 1 : 0;
      if (st[k].lag <= d) return 0;

      center = rows[k][(st[k].out_slot & 3) * MaxW + c % MaxW];
      if (erode) target = (fg_val != 0) ? 8'd0 : PixMax;
      else target = fg_val;
      res = center;
      // erosion looks at all eight neighbors, dilation at the cross only
      if (center != target) begin
        for (int dr = -1; dr <= 1; dr++) begin
          for (int dc = -1; dc <= 1; dc++) begin
            rr = int'(r) + dr;
            cc = int'(c) + dc;
            if (dr == 0 && dc == 0) continue;
            if (!erode && dr != 0 && dc != 0) continue;
            if (rr < 0 || rr >= int'(h) || cc < 0 || cc >= int'(w)) continue;
            slot = (st[k].out_slot + dr + 4) & 3;
            if (rows[k][slot * MaxW + cc % MaxW] == target) hit = 1;
          end
        end
        if (hit) res = target;
      end
      last = (r + 1 >= h && c + 1 >= w);
      st[k].lag--;
      if (c + 1 < w) begin
        st[k].out_col++;
      end else begin
        st[k].out_col  = 0;
        st[k].out_slot = (st[k].out_slot + 1) & 3;
        st[k].out_row  = (r + 1 < h) ? r + 1 : 0;
      end
      return 1;
    endfunction

    function void note_input(logic [7:0] pix, bit flush);
      logic [7:0] r1, r2;
      bit         l1, l2, got1;
      got1 = stage_step(0, !flush, pix, mode == OpErode || mode == OpOpen, r1, l1);
      if (mode == OpDilate || mode == OpErode) begin
        if (got1) pending.push_back('{r1, l1});
      end else if (stage_step(1, got1, r1, mode == OpClose, r2, l2)) begin
        pending.push_back('{r2, l2});
      end
    endfunction

    function void check_result(logic [7:0] pix, logic last);
      result_s exp_r;
      if (pending.size() == 0) begin
        $error("unexpected result: pixel_out %0d frame_last %0d", pix, last);
        errors++;
        return;
      end
      exp_r = pending.pop_front();
      if (pix !== exp_r.pix) begin
        $error("pixel_out: expected %0d, got %0d", exp_r.pix, pix);
        errors++;
      end
      if (last !== exp_r.last) begin
        $error("frame_last: expected %0d, got %0d", exp_r.last, last);
        errors++;
      end
    endfunction
  endclass

  logic        clk_i, rst_ni;
  logic        push, full, empty, pop;
  logic [7:0]  pixel_in_i, pixel_out_o;
  logic        flush_i, frame_last_o;
  logic        cfg_valid, cfg_ready;
  logic [1:0]  cfg_index;
  logic [10:0] cfg_data;

  morph_scoreboard sb = new();
  int          cycles;
  bit          hold_req;
  bit          calm;
  int          items_sent;

  binary_morphology_3x3_unit #(.MaxWidth(MaxW), .MaxHeight(MaxH)) i_dut (
    .clk_i, .rst_ni, .push, .full, .pixel_in_i, .flush_i, .empty, .pop,
    .pixel_out_o, .frame_last_o, .cfg_valid, .cfg_ready, .cfg_index, .cfg_data
  );

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Monitor: accepted items, results, register writes, and the time limit
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (push && !full) sb.note_input(pixel_in_i, flush_i);
      if (pop && !empty) sb.check_result(pixel_out_o, frame_last_o);
      if (cfg_valid && cfg_ready) sb.write_reg(cfg_index, cfg_data);
    end
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  function automatic int draw_gap();
    return calm ? 0 : $urandom_range(0, 7);
  endfunction

  // Result side: random stalls, with one long hold-off on request
  initial begin
    int gap;
    pop = 1'b0;
    @(posedge rst_ni);
    forever begin
      if (hold_req) begin
        hold_req = 0;
        pop <= 1'b0;
        repeat (600) @(posedge clk_i);
      end
      gap = draw_gap();
      if (gap > 0) begin
        pop <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      pop <= 1'b1;
      do @(posedge clk_i); while (empty);
    end
  end

  task automatic send_item(logic [7:0] pix, bit fl);
    int gap;
    gap = draw_gap();
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    push       <= 1'b1;
    pixel_in_i <= pix;
    flush_i    <= fl;
    do @(posedge clk_i); while (full);
    items_sent++;
  endtask

  task automatic write_reg(logic [1:0] idx, logic [10:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk_i); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  // Wait until every expected result has left and the block has settled
  task automatic wait_idle();
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (DrainWait) @(posedge clk_i);
  endtask

  function automatic logic [7:0] pick_pixel(logic [7:0] fg);
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return fg;
      4, 5, 6:    return (fg != 0) ? 8'd0 : PixMax;
      7:          return ~fg;
      default:    return 8'($urandom);
    endcase
  endfunction

  function automatic int clamp(int v, int hi);
    return (v < 1) ? 1 : (v > hi) ? hi : v;
  endfunction

  // One setting: write all registers, stream pixels with some flushes, drain
  task automatic run_phase(int w, int h, logic [7:0] fg, op_mode_e op,
                           int npix, int flush_pct);
    int n;
    wait_idle();
    write_reg(RegWidth, 11'(w));
    write_reg(RegHeight, 11'(h));
    write_reg(RegFgVal, 11'(fg));
    write_reg(RegMode, 11'(op));
    n = 0;
    while (n < npix) begin
      if ($urandom_range(0, 99) < flush_pct) begin
        send_item(8'($urandom), 1'b1);
      end else begin
        send_item(pick_pixel(fg), 1'b0);
        n++;
      end
    end
    // tail drain covers both stages
    repeat (2 * (clamp(w, MaxW) + 2) + 4) send_item(8'($urandom), 1'b1);
    push <= 1'b0;
  endtask

  // Stimulus
  initial begin
    int w, h, we, he, npix;
    cycles     = 0;
    hold_req   = 0;
    calm       = 0;
    items_sent = 0;
    rst_ni     = 1'b0;
    push       = 1'b0;
    pixel_in_i = 8'd0;
    flush_i    = 1'b0;
    cfg_valid  = 1'b0;
    cfg_index  = RegWidth;
    cfg_data   = 11'd0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: a 3x3 frame in every operation, both foreground polarities
    run_phase(3, 3, 8'd255, OpDilate, 9, 0);
    run_phase(3, 3, 8'd0, OpErode, 9, 0);
    run_phase(3, 3, 8'd255, OpOpen, 9, 10);
    run_phase(3, 3, 8'd0, OpClose, 9, 10);
    // degenerate and clamped sizes
    run_phase(0, 0, 8'd255, OpClose, 3, 20);
    run_phase(1, 4, 8'd0, OpDilate, 8, 0);
    run_phase(2047, 3, 8'd255, OpErode, 1040, 2);
    run_phase(3, 2047, 8'd0, OpOpen, 30, 5);
    run_phase(1024, 3, 8'd128, OpDilate, 1030, 0);

    // receiver stalls long while the sender keeps offering
    hold_req = 1;
    run_phase(6, 5, 8'd255, OpDilate, 90, 0);

    // random settings, mostly small frames, sometimes back to back frames
    while (items_sent < 3300) begin
      calm = ($urandom_range(0, 4) == 0);
      case ($urandom_range(0, 19))
        0:       begin w = $urandom_range(0, 2); h = $urandom_range(3, 6); end
        1:       begin w = $urandom_range(3, 6); h = $urandom_range(0, 2); end
        default: begin w = $urandom_range(3, 9); h = $urandom_range(3, 7); end
      endcase
      we = clamp(w, MaxW);
      he = clamp(h, MaxH);
      npix = $urandom_range(1, 3) * we * he + $urandom_range(0, we);
      run_phase(w, h, ($urandom_range(0, 3) == 0) ? 8'($urandom) :
                      ($urandom_range(0, 1) ? PixMax : 8'd0),
                op_mode_e'($urandom_range(0, 3)), npix, $urandom_range(0, 15));
    end
    calm = 0;

    wait_idle();
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
